### hw/rtl/cstu_pkg.sv
// Shared types and constants for the counting semaphore table unit.
// Holds the request and response word layouts, operation and status codes,
// and the sequencer state type. Depends on nothing.
`timescale 1ns / 1ps

package cstu_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_FULL        = 3'd1,
    STAT_BAD_ID      = 3'd2,
    STAT_WOULD_BLOCK = 3'd3,
    STAT_SATURATED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_CHECK = 2'd2,
    S_EXEC  = 2'd3
  } seq_state_e;

  localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;

  typedef struct packed {
    op_e                opcode;
    logic [7:0]         slot_id;
    logic signed [15:0] initial_count;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [3:0]         granted_slot;
    logic signed [15:0] count_after;
  } rsp_t;

  // Result of the shared count update unit.
  typedef struct packed {
    status_e            status;
    logic               wr_en;
    logic signed [15:0] count;
  } upd_t;

endpackage

### hw/rtl/cstu_count_ram.sv
// Count storage for the semaphore slots: one write port, one read port with
// registered read data. Depends on nothing; entries hold no reset value.
`timescale 1ns / 1ps

module cstu_count_ram #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [15:0]      wdata_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic signed [15:0]      rdata_o
);

  logic signed [15:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/cstu_update.sv
// Shared count update unit: decrement for wait, saturating increment for
// signal, with the would-block and saturation decisions. Depends on cstu_pkg.
`timescale 1ns / 1ps

module cstu_update (
  input  cstu_pkg::op_e          op_i,
  input  logic signed [15:0]     count_i,
  output cstu_pkg::upd_t         upd_o
);

  logic signed [15:0] dec;
  logic signed [15:0] inc;
  logic               positive;

  assign dec      = count_i - 16'sd1;
  assign inc      = count_i + 16'sd1;
  assign positive = !count_i[15] && (count_i != 16'sd0);

  always_comb begin
    upd_o.status = cstu_pkg::STAT_BAD_ID;
    upd_o.wr_en  = 1'b0;
    upd_o.count  = 16'sd0;
    case (op_i)
      cstu_pkg::OP_WAIT: begin
        if (positive) begin
          upd_o.status = cstu_pkg::STAT_OK;
          upd_o.wr_en  = 1'b1;
          upd_o.count  = dec;
        end else begin
          upd_o.status = cstu_pkg::STAT_WOULD_BLOCK;
          upd_o.count  = count_i;
        end
      end
      cstu_pkg::OP_SIGNAL: begin
        if (count_i == cstu_pkg::COUNT_MAX) begin
          upd_o.status = cstu_pkg::STAT_SATURATED;
          upd_o.count  = count_i;
        end else begin
          upd_o.status = cstu_pkg::STAT_OK;
          upd_o.wr_en  = 1'b1;
          upd_o.count  = inc;
        end
      end
      default: begin
        upd_o.status = cstu_pkg::STAT_BAD_ID;
        upd_o.wr_en  = 1'b0;
        upd_o.count  = 16'sd0;
      end
    endcase
  end

endmodule

### hw/rtl/counting_semaphore_table_unit.sv
// Top level of the counting semaphore table unit: sequencer, allocated flags,
// output register. Depends on cstu_pkg, cstu_count_ram and cstu_update.
`timescale 1ns / 1ps

// A table of SEM_COUNT semaphores, each an allocated flag and a signed 16-bit
// count. Each request word gives exactly one response word. Allocate takes
// the lowest free slot; wait decrements a positive count or answers would
// block; signal increments and saturates at 32767. The unit handles one
// request at a time and holds in_stall_o high while busy. Wait and signal
// pass through accept, flag check, and count read and update; a bad id
// ends after the flag check. Allocate scans the allocated flags one slot
// per cycle from slot 0 until a free slot or the last slot, where it waits
// for the output register. A new request is accepted while the previous
// response still waits in the output register. Slots are never freed.
module counting_semaphore_table_unit #(
  parameter int SEM_COUNT = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cstu_pkg::req_t  in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cstu_pkg::rsp_t  out_word_o
);

  localparam int IdxW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(SEM_COUNT - 1);
  localparam logic [8:0] SlotLimit = 9'(SEM_COUNT);

  cstu_pkg::seq_state_e state_q, state_d;
  cstu_pkg::req_t       req_q;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [SEM_COUNT-1:0] in_use_q;
  logic                 out_valid_q;
  cstu_pkg::rsp_t       out_word_q;

  logic                 out_free;
  logic [IdxW-1:0]      slot_idx;
  logic                 slot_bad;
  logic                 scan_free;
  logic                 scan_last;
  logic [7:0]           idx_ext;

  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic signed [15:0]   ram_wdata;
  logic signed [15:0]   ram_rdata;
  logic                 set_use;
  logic                 res_load;
  cstu_pkg::rsp_t       res_word;
  cstu_pkg::upd_t       upd;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign slot_idx  = req_q.slot_id[IdxW-1:0];
  assign slot_bad  = (req_q.opcode == cstu_pkg::OP_RSVD) ||
                     ({1'b0, req_q.slot_id} >= SlotLimit) ||
                     !in_use_q[slot_idx];
  assign scan_free = !in_use_q[idx_q];
  assign scan_last = (idx_q == IdxLast);
  assign idx_ext   = 8'(idx_q);

  cstu_count_ram #(
    .Depth (SEM_COUNT),
    .AddrW (IdxW)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_idx),
    .rdata_o (ram_rdata)
  );

  cstu_update u_update (
    .op_i    (req_q.opcode),
    .count_i (ram_rdata),
    .upd_o   (upd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cstu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_word_i.opcode == cstu_pkg::OP_ALLOC) ? cstu_pkg::S_SCAN
                                                              : cstu_pkg::S_CHECK;
        end
      end
      cstu_pkg::S_SCAN: begin
        if ((scan_free || scan_last) && out_free) begin
          state_d = cstu_pkg::S_IDLE;
        end
      end
      cstu_pkg::S_CHECK: begin
        if (!slot_bad) begin
          state_d = cstu_pkg::S_EXEC;
        end else if (out_free) begin
          state_d = cstu_pkg::S_IDLE;
        end
      end
      cstu_pkg::S_EXEC: begin
        if (out_free) begin
          state_d = cstu_pkg::S_IDLE;
        end
      end
      default: state_d = cstu_pkg::S_IDLE;
    endcase
  end

  // Datapath control. Nothing commits until the output register can take
  // the response word, so a stalled item leaves the table untouched.
  always_comb begin
    idx_d                 = idx_q;
    ram_we                = 1'b0;
    ram_waddr             = slot_idx;
    ram_wdata             = upd.count;
    set_use               = 1'b0;
    res_load              = 1'b0;
    res_word.status       = cstu_pkg::STAT_BAD_ID;
    res_word.granted_slot = req_q.slot_id[3:0];
    res_word.count_after  = 16'sd0;
    in_stall_o            = 1'b1;
    case (state_q)
      cstu_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        idx_d      = '0;
      end
      cstu_pkg::S_SCAN: begin
        ram_waddr = idx_q;
        ram_wdata = req_q.initial_count;
        if (scan_free) begin
          res_word.status       = cstu_pkg::STAT_OK;
          res_word.granted_slot = idx_ext[3:0];
          res_word.count_after  = req_q.initial_count;
          if (out_free) begin
            res_load = 1'b1;
            ram_we   = 1'b1;
            set_use  = 1'b1;
          end
        end else if (scan_last) begin
          res_word.status       = cstu_pkg::STAT_FULL;
          res_word.granted_slot = 4'd0;
          res_load              = out_free;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      cstu_pkg::S_CHECK: begin
        res_load = slot_bad && out_free;
      end
      cstu_pkg::S_EXEC: begin
        res_word.status      = upd.status;
        res_word.count_after = upd.count;
        if (out_free) begin
          res_load = 1'b1;
          ram_we   = upd.wr_en;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cstu_pkg::S_IDLE;
      idx_q    <= '0;
      in_use_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (set_use) begin
        in_use_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  // Slots are never freed, so the number of allocated slots never drops.
  a_alloc_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_use_q) >= $past($countones(in_use_q)))
    else $error("allocated slot count decreased");

  // The count store is only written together with a response word.
  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> res_load)
    else $error("count written without a response");

  // Table full is reported only when every slot is taken.
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_word.status == cstu_pkg::STAT_FULL) |-> (&in_use_q))
    else $error("table full reported with a free slot");

  // A response is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !res_load)
    else $error("stalled response word overwritten");
`endif

endmodule

### bench/semaphore_table_checker.sv
`timescale 1ns / 1ps
// Response checker for the counting semaphore table unit: keeps its own copy
// of the slot table, predicts one response word per accepted request word and
// compares it with the unit's output. Depends on cstu_pkg.

module semaphore_table_checker #(
  parameter int SEM_COUNT = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  cstu_pkg::req_t  in_word_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  cstu_pkg::rsp_t  out_word_i,
  output int              mismatches_o,
  output int              pending_o
);

  logic               slot_taken [SEM_COUNT];
  logic signed [15:0] slot_value [SEM_COUNT];
  cstu_pkg::rsp_t     rsp_owed [$];

  // Applies one request to the mirrored table and returns the response word
  // that the unit has to give for it.
  function automatic cstu_pkg::rsp_t run_semaphore_op(input cstu_pkg::req_t rq);
    cstu_pkg::rsp_t     r;
    logic signed [15:0] c;
    bit                 placed;
    r.status       = cstu_pkg::STAT_BAD_ID;
    r.granted_slot = rq.slot_id[3:0];
    r.count_after  = '0;
    placed         = 1'b0;
    case (rq.opcode)
      cstu_pkg::OP_ALLOC: begin
        r.status       = cstu_pkg::STAT_FULL;
        r.granted_slot = '0;
        for (int s = 0; s < SEM_COUNT; s++) begin
          if (!placed && !slot_taken[s]) begin
            placed         = 1'b1;
            slot_taken[s]  = 1'b1;
            slot_value[s]  = rq.initial_count;
            r.status       = cstu_pkg::STAT_OK;
            r.granted_slot = 4'(s);
            r.count_after  = rq.initial_count;
          end
        end
      end
      cstu_pkg::OP_WAIT: begin
        if (rq.slot_id < SEM_COUNT && slot_taken[rq.slot_id]) begin
          c = slot_value[rq.slot_id];
          if (c > 0) begin
            c = c - 16'sd1;
            slot_value[rq.slot_id] = c;
            r.status = cstu_pkg::STAT_OK;
          end else begin
            r.status = cstu_pkg::STAT_WOULD_BLOCK;
          end
          r.count_after = c;
        end
      end
      cstu_pkg::OP_SIGNAL: begin
        if (rq.slot_id < SEM_COUNT && slot_taken[rq.slot_id]) begin
          c = slot_value[rq.slot_id];
          if (c == cstu_pkg::COUNT_MAX) begin
            r.status = cstu_pkg::STAT_SATURATED;
          end else begin
            c = c + 16'sd1;
            slot_value[rq.slot_id] = c;
            r.status = cstu_pkg::STAT_OK;
          end
          r.count_after = c;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cstu_pkg::rsp_t want;
    if (!rst_ni) begin
      for (int s = 0; s < SEM_COUNT; s++) begin
        slot_taken[s] = 1'b0;
        slot_value[s] = '0;
      end
      rsp_owed.delete();
      mismatches_o = 0;
    end else begin
      // The prediction is queued first, so a word accepted and answered at
      // the same edge would still line up.
      if (in_valid_i && !in_stall_i) begin
        rsp_owed.push_back(run_semaphore_op(in_word_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (rsp_owed.size() == 0) begin
          $error("response word with none owed: status %0d, granted_slot %0d, count_after %0d",
                 out_word_i.status, out_word_i.granted_slot, out_word_i.count_after);
          mismatches_o++;
        end else begin
          want = rsp_owed.pop_front();
          if (out_word_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word_i.status);
            mismatches_o++;
          end
          if (out_word_i.granted_slot !== want.granted_slot) begin
            $error("granted_slot: expected %0d, got %0d",
                   want.granted_slot, out_word_i.granted_slot);
            mismatches_o++;
          end
          if (out_word_i.count_after !== want.count_after) begin
            $error("count_after: expected %0d, got %0d",
                   want.count_after, out_word_i.count_after);
            mismatches_o++;
          end
        end
      end
    end
    pending_o = rsp_owed.size();
  end

endmodule

### bench/counting_semaphore_table_unit_tb.sv
`timescale 1ns / 1ps
// Top of the counting semaphore table testbench: clock, reset, request and
// response drivers, run limit and verdict. Depends on cstu_pkg, the unit
// counting_semaphore_table_unit and semaphore_table_checker.

module counting_semaphore_table_unit_tb;

  localparam int SEM_COUNT     = 16;
  localparam int RANDOM_WORDS  = 900;
  localparam int SETTLE_CYCLES = 2 * (SEM_COUNT + 2) + 16;
  localparam int CYCLE_LIMIT   = 400000;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  cstu_pkg::req_t in_word;
  logic           out_valid;
  logic           out_stall;
  cstu_pkg::rsp_t out_word;
  int             mismatches;
  int             pending;
  int             run_cycles = 0;
  bit             send_calm = 1'b0;
  bit             drain_calm = 1'b0;

  logic signed [15:0] start_counts [SEM_COUNT];

  always #1 clk = ~clk;

  counting_semaphore_table_unit #(
    .SEM_COUNT(SEM_COUNT)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  semaphore_table_checker #(
    .SEM_COUNT(SEM_COUNT)
  ) u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  function automatic cstu_pkg::req_t sem_req(input cstu_pkg::op_e op, input logic [7:0] id,
                                             input logic signed [15:0] init);
    cstu_pkg::req_t w;
    w.opcode        = op;
    w.slot_id       = id;
    w.initial_count = init;
    return w;
  endfunction

  // Offers one request word after a random gap and returns at the edge where
  // it is taken. Valid stays high between back-to-back words.
  task automatic push_request(input cstu_pkg::req_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : response_drain
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) drain_calm = !drain_calm;
      hold = drain_calm ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid || out_stall);
    end
  end

  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    start_counts = '{16'sh7FFF, 16'sh7FFE, 16'sh8000, 16'sh0000,
                     16'sh0001, 16'shFFFF, 16'sh8001, 16'sh0002,
                     16'sh0064, 16'shFF9C, 16'sh5555, 16'shAAAA,
                     16'sh7FF0, 16'sh000A, 16'sh7FFA, 16'sh0003};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Every slot is still free, so wait and signal find unallocated or out-of-range ids.
    push_request(sem_req(cstu_pkg::OP_WAIT, 8'd0, 16'sh0000));
    push_request(sem_req(cstu_pkg::OP_SIGNAL, 8'd15, 16'sh7FFF));
    push_request(sem_req(cstu_pkg::OP_RSVD, 8'd0, 16'sh8000));
    push_request(sem_req(cstu_pkg::OP_WAIT, 8'd255, 16'shFFFF));
    push_request(sem_req(cstu_pkg::OP_SIGNAL, 8'd16, 16'sh0001));
    // Fill the table; slots are never freed, so it stays full from here on.
    for (int s = 0; s < SEM_COUNT; s++) begin
      push_request(sem_req(cstu_pkg::OP_ALLOC, 8'($urandom), start_counts[s]));
    end
    push_request(sem_req(cstu_pkg::OP_ALLOC, 8'd0, 16'sh1234));
    push_request(sem_req(cstu_pkg::OP_SIGNAL, 8'd0, 16'sh0000));
    push_request(sem_req(cstu_pkg::OP_WAIT, 8'd3, 16'sh0000));
    push_request(sem_req(cstu_pkg::OP_WAIT, 8'd2, 16'sh0000));
    push_request(sem_req(cstu_pkg::OP_WAIT, 8'd4, 16'sh0000));
    push_request(sem_req(cstu_pkg::OP_SIGNAL, 8'd1, 16'sh0000));

    // Mostly wait and signal on live slots, with counts walking around the
    // saturation point, zero and the negative range; the rest is noise.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        push_request(sem_req(cstu_pkg::OP_ALLOC, 8'($urandom), 16'($urandom)));
      end else if (pick < 9) begin
        push_request(sem_req(cstu_pkg::OP_RSVD, 8'($urandom), 16'($urandom)));
      end else if (pick < 16) begin
        push_request(sem_req(pick[0] ? cstu_pkg::OP_WAIT : cstu_pkg::OP_SIGNAL,
                             8'($urandom_range(SEM_COUNT, 255)), 16'($urandom)));
      end else begin
        push_request(sem_req($urandom_range(0, 1) ? cstu_pkg::OP_WAIT : cstu_pkg::OP_SIGNAL,
                             8'($urandom_range(0, SEM_COUNT - 1)), 16'($urandom)));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
